// File: rtl/core/swam_pkg.sv
// Shared types and constants for the sliding window anagram matcher.
// No dependencies.
`default_nettype none

package swam_pkg;

  localparam int LETTER_W = 5;
  localparam int ACT_W    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PATTERN = 2'd0,
    ACT_TEXT    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // per-word control broadcast to every letter lane
  typedef struct packed {
    logic                en;
    logic                pat_add;
    logic                wipe_pat;
    logic                wipe_win;
    logic                txt;
    logic                evict;
    logic [LETTER_W-1:0] add_letter;
    logic [LETTER_W-1:0] sub_letter;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/swam_lane.sv
// One letter lane: pattern and window counts for a single letter code.
// Depends on swam_pkg.
`default_nettype none

module swam_lane
  import swam_pkg::*;
#(
  parameter int LETTER = 0,
  parameter int CNT_W  = 9
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lane_ctl_t ctl,
  output logic           differ_next
);

  logic [CNT_W-1:0] pat_count;
  logic [CNT_W-1:0] win_count;
  logic [CNT_W-1:0] pat_count_next;
  logic [CNT_W-1:0] win_count_next;
  logic             hit_add;
  logic             hit_sub;

  assign hit_add = (32'(ctl.add_letter) == LETTER);
  assign hit_sub = (32'(ctl.sub_letter) == LETTER) && ctl.evict;

  always_comb begin
    pat_count_next = pat_count;
    win_count_next = win_count;
    if (ctl.en) begin
      if (ctl.wipe_pat) begin
        pat_count_next = '0;
      end else if (ctl.pat_add && hit_add) begin
        pat_count_next = pat_count + CNT_W'(1);
      end
      if (ctl.wipe_win) begin
        win_count_next = '0;
      end else if (ctl.txt) begin
        win_count_next = win_count + CNT_W'(hit_add) - CNT_W'(hit_sub);
      end
    end
  end

  assign differ_next = (win_count_next != pat_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_count <= '0;
      win_count <= '0;
    end else begin
      pat_count <= pat_count_next;
      win_count <= win_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swam_ring.sv
// Ring of recent text letters: one write and one registered read per cycle.
// A read of the address being written returns the new word. Depends on swam_pkg.
`default_nettype none

module swam_ring
  import swam_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [LETTER_W-1:0] wdata,
  input  wire logic [AW-1:0]       raddr,
  output logic      [LETTER_W-1:0] rdata
);

  logic [LETTER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_anagram_matcher.sv
// Sliding window anagram matcher: top level with input and result registers.
// Depends on swam_pkg, swam_lane and swam_ring.
//
// Takes one word per cycle unless the output side stalls and returns exactly one result
// word for each, through the input and result registers. The cycle is set by the letter
// lanes (increment, decrement and compare of one letter's counts) and the OR over all
// lanes; the evicted letter comes from the ring memory, whose registered read is issued
// ahead from the pointer state that the word now executing leaves behind. No clearing
// pass after reset: ring entries are only read once written since the last pattern change.
`default_nettype none

module sliding_window_anagram_matcher
  import swam_pkg::*;
#(
  parameter int MAX_PATTERN = 256,
  parameter int ALPHABET    = 26,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [LETTER_W-1:0]   letter,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       match,
  output logic      [INDEX_BITS-1:0] start_index,
  output logic                       pattern_overflow
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // input register
  logic                in_full;
  action_t             act_q;
  logic [LETTER_W-1:0] letter_q;

  // state
  logic [LEN_W-1:0]      plen;
  logic [LEN_W-1:0]      fill;
  logic [RING_W-1:0]     rp;
  logic [INDEX_BITS-1:0] tp;
  logic [LEN_W-1:0]      plen_next;
  logic [LEN_W-1:0]      fill_next;
  logic [RING_W-1:0]     rp_next;
  logic [INDEX_BITS-1:0] tp_next;

  logic fire;
  logic is_pat;
  logic is_txt;
  logic is_clr;
  logic pat_full;
  logic in_alpha;
  logic pat_add;
  logic txt;
  logic evict;
  logic restart;

  logic [LETTER_W-1:0] old_letter;
  logic [RING_W-1:0]   rd_addr;
  logic [LEN_W:0]      rd_sum;
  lane_ctl_t           ctl;
  logic [ALPHABET-1:0] differ;

  logic                  match_next;
  logic [INDEX_BITS-1:0] start_next;

  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  assign is_pat   = (act_q == ACT_PATTERN);
  assign is_txt   = (act_q == ACT_TEXT);
  assign is_clr   = (act_q == ACT_CLEAR);
  assign pat_full = (plen == LEN_W'(MAX_PATTERN));
  assign in_alpha = (32'(letter_q) < ALPHABET);
  assign pat_add  = is_pat && !pat_full && in_alpha;
  assign txt      = is_txt && (plen != '0);
  assign evict    = (fill == plen);
  assign restart  = pat_add || is_clr;

  always_comb begin
    plen_next = plen;
    fill_next = fill;
    rp_next   = rp;
    tp_next   = tp;
    if (fire) begin
      if (is_clr) begin
        plen_next = '0;
      end else if (pat_add) begin
        plen_next = plen + LEN_W'(1);
      end
      if (restart) begin
        fill_next = '0;
        rp_next   = '0;
        tp_next   = '0;
      end else if (is_txt) begin
        tp_next = tp + INDEX_BITS'(1);
        if (txt) begin
          if (!evict) begin
            fill_next = fill + LEN_W'(1);
          end
          rp_next = (rp == RING_W'(MAX_PATTERN - 1)) ? '0 : rp + RING_W'(1);
        end
      end
    end
  end

  // slot of the letter leaving the window for the word after this one
  assign rd_sum  = (LEN_W + 1)'(rp_next) + (LEN_W + 1)'(MAX_PATTERN) - (LEN_W + 1)'(plen_next);
  assign rd_addr = (rd_sum >= (LEN_W + 1)'(MAX_PATTERN))
                 ? RING_W'(rd_sum - (LEN_W + 1)'(MAX_PATTERN))
                 : RING_W'(rd_sum);

  swam_ring #(
    .DEPTH (MAX_PATTERN),
    .AW    (RING_W)
  ) u_ring (
    .clk   (clk),
    .we    (fire && txt),
    .waddr (rp),
    .wdata (letter_q),
    .raddr (rd_addr),
    .rdata (old_letter)
  );

  always_comb begin
    ctl.en         = fire;
    ctl.pat_add    = pat_add;
    ctl.wipe_pat   = is_clr;
    ctl.wipe_win   = restart;
    ctl.txt        = txt;
    ctl.evict      = evict;
    ctl.add_letter = letter_q;
    ctl.sub_letter = old_letter;
  end

  for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
    swam_lane #(
      .LETTER (k),
      .CNT_W  (LEN_W)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .differ_next (differ[k])
    );
  end

  assign match_next = txt && (fill_next == plen) && !(|differ);
  assign start_next = match_next ? (tp - (INDEX_BITS'(plen) - INDEX_BITS'(1))) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q    <= action_t'(action);
      letter_q <= letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      fill <= '0;
      rp   <= '0;
      tp   <= '0;
    end else begin
      plen <= plen_next;
      fill <= fill_next;
      rp   <= rp_next;
      tp   <= tp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      match            <= match_next;
      start_index      <= start_next;
      pattern_overflow <= is_pat && pat_full;
    end
  end

  a_plen_cap : assert property (@(posedge clk) disable iff (rst)
    plen <= LEN_W'(MAX_PATTERN))
    else $error("pattern length above capacity");

  a_fill_cap : assert property (@(posedge clk) disable iff (rst)
    fill <= plen)
    else $error("window fill above pattern length");

  a_ring_ptr : assert property (@(posedge clk) disable iff (rst)
    32'(rp) < MAX_PATTERN)
    else $error("ring pointer out of range");

  a_clear : assert property (@(posedge clk) disable iff (rst)
    fire && is_clr |=> (plen == '0) && (fill == '0) && (tp == '0))
    else $error("clear left state behind");

  a_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid && match |-> !pattern_overflow)
    else $error("match and overflow in one word");

endmodule

`default_nettype wire
